// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plane side classifier: assertion failed");

// Next-cycle implication
`define PSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plane side classifier: assertion failed");

`endif

// File: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Widths, codes, register reset values and shared types of the plane side
// classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Field and datapath widths
    localparam int NRM_W            = 18;
    localparam int COORD_W          = 32;
    localparam int OFF_W            = 32;
    localparam int TOL_W            = 31;
    localparam int OP_W             = 3;
    localparam int SIDE_W           = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int NORMAL_FRAC_BITS = 16;
    localparam int NUM_PTS          = 3;
    localparam int NUM_AXES         = 3;
    localparam int PT_W             = COORD_W + 1;
    localparam int THR_W            = COORD_W + 1;
    localparam int PROD_W           = PT_W + NRM_W;
    localparam int SUM_W            = PROD_W + 1;
    localparam int DIST_W           = SUM_W + 1;

    // Primitive codes
    localparam logic [OP_W-1:0] OP_POINT    = 3'd0;
    localparam logic [OP_W-1:0] OP_SEGMENT  = 3'd1;
    localparam logic [OP_W-1:0] OP_TRIANGLE = 3'd2;
    localparam logic [OP_W-1:0] OP_SPHERE   = 3'd3;
    localparam logic [OP_W-1:0] OP_BOX      = 3'd4;

    // Side codes
    localparam logic [SIDE_W-1:0] SIDE_ON   = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_POS  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_NEG  = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_BOTH = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TOLERANCE = 3'd4;

    // Register reset values
    localparam logic [NRM_W-1:0] RST_NORMAL_X     = 18'sd0;
    localparam logic [NRM_W-1:0] RST_NORMAL_Y     = 18'sd0;
    localparam logic [NRM_W-1:0] RST_NORMAL_Z     = 18'sd65536;
    localparam logic [OFF_W-1:0] RST_PLANE_OFFSET = 32'sd0;
    localparam logic [TOL_W-1:0] RST_ON_TOLERANCE = 31'd65;

    // Plane registers
    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [OFF_W-1:0] offset;
        logic        [TOL_W-1:0] tol;
    } cfg_t;

    // One point, exact 33-bit coordinates
    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } point_t;

    // Per-item side information travelling with the distances
    typedef struct packed {
        logic        [OP_W-1:0]  op;
        logic signed [THR_W-1:0] thr;
    } meta_t;

    // Load enables of the distance lanes
    typedef struct packed {
        logic mul;
        logic sum;
        logic sdist;
    } lane_en_t;

endpackage

// File: rtl/plane_side_classifier_top.sv
// ----------------------------------------------------------------------------
// plane_side_classifier_top: a beat passes the front register, the lane
// product, sum and distance registers and the output register. Throughput one
// item per cycle; a stage holds only while it is full and the next one holds.
// Reset (rst_n low) empties the pipe and loads the plane registers defaults.
// ----------------------------------------------------------------------------
module plane_side_classifier_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [psc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [psc_pkg::OP_W-1:0]       op,
    input  logic signed [psc_pkg::COORD_W-1:0]    first_x,
    input  logic signed [psc_pkg::COORD_W-1:0]    first_y,
    input  logic signed [psc_pkg::COORD_W-1:0]    first_z,
    input  logic signed [psc_pkg::COORD_W-1:0]    second_x,
    input  logic signed [psc_pkg::COORD_W-1:0]    second_y,
    input  logic signed [psc_pkg::COORD_W-1:0]    second_z,
    input  logic signed [psc_pkg::COORD_W-1:0]    third_x,
    input  logic signed [psc_pkg::COORD_W-1:0]    third_y,
    input  logic signed [psc_pkg::COORD_W-1:0]    third_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [psc_pkg::SIDE_W-1:0]     side
);
    import psc_pkg::*;

    cfg_t                     cfg_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     v4_reg;
    logic                     rdy1;
    logic                     rdy2;
    logic                     rdy3;
    logic                     rdy4;
    logic                     rdy5;
    lane_en_t                 lane_en;
    point_t                   pts [NUM_PTS];
    meta_t                    meta1;
    meta_t                    meta2_reg;
    meta_t                    meta3_reg;
    meta_t                    meta4_reg;
    logic signed [DIST_W-1:0] sdist [NUM_PTS];

    // Plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nx     <= RST_NORMAL_X;
            cfg_reg.ny     <= RST_NORMAL_Y;
            cfg_reg.nz     <= RST_NORMAL_Z;
            cfg_reg.offset <= RST_PLANE_OFFSET;
            cfg_reg.tol    <= RST_ON_TOLERANCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMAL_X:     cfg_reg.nx     <= cfg_data[NRM_W-1:0];
                CFG_NORMAL_Y:     cfg_reg.ny     <= cfg_data[NRM_W-1:0];
                CFG_NORMAL_Z:     cfg_reg.nz     <= cfg_data[NRM_W-1:0];
                CFG_PLANE_OFFSET: cfg_reg.offset <= cfg_data[OFF_W-1:0];
                CFG_ON_TOLERANCE: cfg_reg.tol    <= cfg_data[TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Ready chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        rdy5          = !out_valid || !out_stall;
        rdy4          = !v4_reg || rdy5;
        rdy3          = !v3_reg || rdy4;
        rdy2          = !v2_reg || rdy3;
        rdy1          = !v1_reg || rdy2;
        lane_en.mul   = rdy2 && v1_reg;
        lane_en.sum   = rdy3 && v2_reg;
        lane_en.sdist = rdy4 && v3_reg;
    end

    assign in_stall = !rdy1;

    // Valid bits of the inner stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // Carry op and threshold beside the distances
    always_ff @(posedge clk)
    begin
        if (lane_en.mul)
            meta2_reg <= meta1;
        if (lane_en.sum)
            meta3_reg <= meta2_reg;
        if (lane_en.sdist)
            meta4_reg <= meta3_reg;
    end

    psc_front u_front (
        .clk      (clk),
        .en       (rdy1 && in_valid),
        .cfg      (cfg_reg),
        .op       (op),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .third_x  (third_x),
        .third_y  (third_y),
        .third_z  (third_z),
        .pts      (pts),
        .meta     (meta1)
    );

    // One distance lane per point
    for (genvar g = 0; g < NUM_PTS; g++)
    begin : g_lane
        psc_lane u_lane (
            .clk   (clk),
            .en    (lane_en),
            .cfg   (cfg_reg),
            .pt    (pts[g]),
            .sdist (sdist[g])
        );
    end

    psc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .ready     (rdy5),
        .in_valid  (v4_reg),
        .meta      (meta4_reg),
        .sdist     (sdist),
        .out_valid (out_valid),
        .side      (side)
    );

endmodule

// File: rtl/psc_front.sv
// ----------------------------------------------------------------------------
// psc_front
// Input register: forms the three points of a primitive (box far corners
// included) and the test threshold (second_x for a sphere, else the tolerance).
// ----------------------------------------------------------------------------
module psc_front (
    input  logic                                  clk,
    input  logic                                  en,
    input  psc_pkg::cfg_t                         cfg,
    input  logic        [psc_pkg::OP_W-1:0]       op,
    input  logic signed [psc_pkg::COORD_W-1:0]    first_x,
    input  logic signed [psc_pkg::COORD_W-1:0]    first_y,
    input  logic signed [psc_pkg::COORD_W-1:0]    first_z,
    input  logic signed [psc_pkg::COORD_W-1:0]    second_x,
    input  logic signed [psc_pkg::COORD_W-1:0]    second_y,
    input  logic signed [psc_pkg::COORD_W-1:0]    second_z,
    input  logic signed [psc_pkg::COORD_W-1:0]    third_x,
    input  logic signed [psc_pkg::COORD_W-1:0]    third_y,
    input  logic signed [psc_pkg::COORD_W-1:0]    third_z,
    output psc_pkg::point_t                       pts [psc_pkg::NUM_PTS],
    output psc_pkg::meta_t                        meta
);
    import psc_pkg::*;

    logic signed [PT_W-1:0] a_ext [NUM_AXES];
    logic signed [PT_W-1:0] b_ext [NUM_AXES];
    logic signed [PT_W-1:0] p0    [NUM_AXES];
    logic signed [PT_W-1:0] p1    [NUM_AXES];
    logic                   n_neg [NUM_AXES];
    point_t                 pts_next [NUM_PTS];
    point_t                 pts_reg  [NUM_PTS];
    meta_t                  meta_next;
    meta_t                  meta_reg;

    // Widen the first two vertices by one bit for exact corners
    always_comb
    begin
        a_ext[0] = PT_W'(first_x);
        a_ext[1] = PT_W'(first_y);
        a_ext[2] = PT_W'(first_z);
        b_ext[0] = PT_W'(second_x);
        b_ext[1] = PT_W'(second_y);
        b_ext[2] = PT_W'(second_z);
        n_neg[0] = cfg.nx[NRM_W-1];
        n_neg[1] = cfg.ny[NRM_W-1];
        n_neg[2] = cfg.nz[NRM_W-1];
    end

    // Pick the far corners of a box by the normal signs
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (op == OP_BOX)
            begin
                p0[i] = n_neg[i] ? (a_ext[i] + b_ext[i]) : (a_ext[i] - b_ext[i]);
                p1[i] = n_neg[i] ? (a_ext[i] - b_ext[i]) : (a_ext[i] + b_ext[i]);
            end
            else
            begin
                p0[i] = a_ext[i];
                p1[i] = b_ext[i];
            end
        end
    end

    // Assemble points and threshold
    always_comb
    begin
        pts_next[0].x = p0[0];
        pts_next[0].y = p0[1];
        pts_next[0].z = p0[2];
        pts_next[1].x = p1[0];
        pts_next[1].y = p1[1];
        pts_next[1].z = p1[2];
        pts_next[2].x = PT_W'(third_x);
        pts_next[2].y = PT_W'(third_y);
        pts_next[2].z = PT_W'(third_z);
        meta_next.op  = op;
        if (op == OP_SPHERE)
        begin
            meta_next.thr = THR_W'(second_x);
        end
        else
        begin
            meta_next.thr = $signed({{(THR_W-TOL_W){1'b0}}, cfg.tol});
        end
    end

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pts_reg  <= pts_next;
            meta_reg <= meta_next;
        end
    end

    assign pts  = pts_reg;
    assign meta = meta_reg;

endmodule

// File: rtl/psc_lane.sv
// ----------------------------------------------------------------------------
// psc_lane
// Exact signed distance of one point from the plane over three stages:
// products, partial sums, final sum.
// ----------------------------------------------------------------------------
module psc_lane (
    input  logic                               clk,
    input  psc_pkg::lane_en_t                  en,
    input  psc_pkg::cfg_t                      cfg,
    input  psc_pkg::point_t                    pt,
    output logic signed [psc_pkg::DIST_W-1:0]  sdist
);
    import psc_pkg::*;

    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    logic signed [SUM_W-1:0]  off_scaled;
    logic signed [SUM_W-1:0]  sum_xy_next;
    logic signed [SUM_W-1:0]  sum_zo_next;
    logic signed [SUM_W-1:0]  sum_xy_reg;
    logic signed [SUM_W-1:0]  sum_zo_reg;
    logic signed [DIST_W-1:0] dist_next;
    logic signed [DIST_W-1:0] dist_reg;

    // Multiply each coordinate by its normal component
    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_x_reg <= PROD_W'(pt.x) * PROD_W'(cfg.nx);
            prod_y_reg <= PROD_W'(pt.y) * PROD_W'(cfg.ny);
            prod_z_reg <= PROD_W'(pt.z) * PROD_W'(cfg.nz);
        end
    end

    // Bring the offset to the product scale and form partial sums
    always_comb
    begin
        off_scaled  = $signed({{(SUM_W-OFF_W-NORMAL_FRAC_BITS){cfg.offset[OFF_W-1]}},
                               cfg.offset, {NORMAL_FRAC_BITS{1'b0}}});
        sum_xy_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg);
        sum_zo_next = SUM_W'(prod_z_reg) - off_scaled;
        dist_next   = DIST_W'(sum_xy_reg) + DIST_W'(sum_zo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            sum_xy_reg <= sum_xy_next;
            sum_zo_reg <= sum_zo_next;
        end
    end

    // Final distance
    always_ff @(posedge clk)
    begin
        if (en.sdist)
        begin
            dist_reg <= dist_next;
        end
    end

    assign sdist = dist_reg;

endmodule

// File: rtl/psc_classify.sv
// ----------------------------------------------------------------------------
// psc_classify
// Compares each distance with the scaled threshold, merges the point classes
// by primitive and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module psc_classify (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ready,
    input  logic                               in_valid,
    input  psc_pkg::meta_t                     meta,
    input  logic signed [psc_pkg::DIST_W-1:0]  sdist [psc_pkg::NUM_PTS],
    output logic                               out_valid,
    output logic        [psc_pkg::SIDE_W-1:0]  side
);
    import psc_pkg::*;

    logic signed [DIST_W-1:0] thr_hi;
    logic signed [DIST_W-1:0] thr_lo;
    logic [NUM_PTS-1:0]       is_pos;
    logic [NUM_PTS-1:0]       is_neg;
    logic [NUM_PTS-1:0]       is_on;
    logic                     any_pos;
    logic                     any_neg;
    logic                     all_on;
    logic [SIDE_W-1:0]        side_next;
    logic [SIDE_W-1:0]        side_reg;
    logic                     valid_reg;

    // Scale the threshold to the distance format
    always_comb
    begin
        thr_hi = $signed({{(DIST_W-THR_W-NORMAL_FRAC_BITS){meta.thr[THR_W-1]}},
                          meta.thr, {NORMAL_FRAC_BITS{1'b0}}});
        thr_lo = -thr_hi;
    end

    // Classify each point, positive test first
    always_comb
    begin
        for (int i = 0; i < NUM_PTS; i++)
        begin
            is_pos[i] = sdist[i] > thr_hi;
            is_neg[i] = !is_pos[i] && (sdist[i] < thr_lo);
            is_on[i]  = !is_pos[i] && !is_neg[i];
        end
    end

    // Merge vertex classes and map the sphere and box tests
    always_comb
    begin
        any_pos   = 1'b0;
        any_neg   = 1'b0;
        all_on    = 1'b0;
        side_next = SIDE_ON;
        case (meta.op)
            OP_POINT:
            begin
                any_pos = is_pos[0];
                any_neg = is_neg[0];
                all_on  = is_on[0];
            end
            OP_SEGMENT:
            begin
                any_pos = is_pos[0] || is_pos[1];
                any_neg = is_neg[0] || is_neg[1];
                all_on  = is_on[0] && is_on[1];
            end
            OP_TRIANGLE:
            begin
                any_pos = |is_pos;
                any_neg = |is_neg;
                all_on  = &is_on;
            end
            default:
            begin
            end
        endcase

        case (meta.op)
            OP_POINT, OP_SEGMENT, OP_TRIANGLE:
            begin
                if (all_on)
                    side_next = SIDE_ON;
                else if (!any_neg)
                    side_next = SIDE_POS;
                else if (!any_pos)
                    side_next = SIDE_NEG;
                else
                    side_next = SIDE_BOTH;
            end
            OP_SPHERE:
            begin
                if (is_pos[0])
                    side_next = SIDE_POS;
                else if (is_neg[0])
                    side_next = SIDE_NEG;
                else
                    side_next = SIDE_BOTH;
            end
            OP_BOX:
            begin
                if (is_pos[0])
                    side_next = SIDE_POS;
                else if (is_neg[1])
                    side_next = SIDE_NEG;
                else
                    side_next = SIDE_BOTH;
            end
            default:
            begin
                side_next = SIDE_ON;
            end
        endcase
    end

    // Output register: advance when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;

endmodule

// File: rtl/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the plane side classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [psc_pkg::SIDE_W-1:0]        side
);
    import psc_pkg::*;

    logic       in_beat;
    logic       out_free;
    logic [3:0] free_hist_reg;

    // Input beat taken, and an output that is free while out of reset
    assign in_beat  = rst_n && in_valid && !in_stall;
    assign out_free = rst_n && !out_stall;

    // Keep a history of a free output, newest in bit 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            free_hist_reg <= '0;
        else
            free_hist_reg <= {free_hist_reg[2:0], out_free};
    end

    // Hold a stalled result beat
    `PSC_ASSERT_NXT(a_out_hold_valid, out_valid && out_stall, out_valid)
    `PSC_ASSERT_NXT(a_out_hold_side, out_valid && out_stall, $stable(side))

    // Input back-pressure only while a result sits stalled at the output
    `PSC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // A taken beat passes the front, lane and output registers to out_valid while the output stays free
    `PSC_ASSERT_IMP(a_latency, $past(in_beat, 5) && (&free_hist_reg), out_valid)

endmodule

bind plane_side_classifier_top psc_checker u_psc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .side      (side)
);
